### hw/rtl/afcc_pkg.sv
package afcc_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 14;
    localparam logic [3:0] PARITY_START = 4'd11;
    localparam logic [3:0] PARITY_MID = 4'd12;
    localparam logic [3:0] PARITY_END = 4'd13;
    localparam logic [3:0] LEN_GOOD = 4'd14;
    localparam logic [3:0] COUNT_MAX = 4'd15;
    localparam logic [3:0] LAST_PAYLOAD_BYTE = 4'd10;
    localparam logic [6:0] LAST_BIT = 7'd111;

    // crc-24 generator without its top bit
    localparam logic [23:0] POLY_LOW = 24'hFFF409;

    // message fields
    localparam logic [4:0] DF_EXT_SQUITTER = 5'd17;
    localparam logic [4:0] TC_IDENT_LO = 5'd1;
    localparam logic [4:0] TC_IDENT_HI = 5'd4;
    localparam logic [4:0] TC_POS_LO = 5'd9;
    localparam logic [4:0] TC_POS_HI = 5'd18;
    localparam logic [4:0] TC_VELOCITY = 5'd19;

    // result status codes
    localparam logic [2:0] ST_IDENT = 3'd0;
    localparam logic [2:0] ST_AIR_POS = 3'd1;
    localparam logic [2:0] ST_VELOCITY = 3'd2;
    localparam logic [2:0] ST_BAD_LEN = 3'd3;
    localparam logic [2:0] ST_UNCORR = 3'd4;
    localparam logic [2:0] ST_NOT_DF17 = 3'd5;
    localparam logic [2:0] ST_OTHER = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_CLASSIFY
    } state_t;

    // fold one frame byte into the running remainder
    function automatic logic [23:0] crc_absorb(
        input logic [23:0] rem,
        input logic [3:0]  pos,
        input logic [7:0]  b
    );
        logic [23:0] r;
        r = rem;
        priority if (pos < PARITY_START)
        begin
            r = r ^ {b, 16'h0000};
            for (int k = 0; k < 8; k++)
            begin
                r = {r[22:0], 1'b0} ^ (r[23] ? POLY_LOW : 24'h000000);
            end
        end
        else if (pos == PARITY_START)
        begin
            r = r ^ {b, 16'h0000};
        end
        else if (pos == PARITY_MID)
        begin
            r = r ^ {8'h00, b, 8'h00};
        end
        else if (pos == PARITY_END)
        begin
            r = r ^ {16'h0000, b};
        end
        else
        begin
            // bytes past the frame leave the remainder alone
            r = rem;
        end
        return r;
    endfunction

    // multiply by x modulo the generator
    function automatic logic [23:0] crc_mul_x(input logic [23:0] v);
        return {v[22:0], 1'b0} ^ (v[23] ? POLY_LOW : 24'h000000);
    endfunction

endpackage

### hw/rtl/afcc_ram.sv
module afcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/adsb_frame_crc_correct_classify_core.sv
// extended squitter receiver: crc-24 check, single-bit repair, classification
//
// input: a frame byte is taken at a rising edge with start high and busy low;
// frame_byte carries the byte msb first, last_byte marks the final byte.
// non-final bytes leave busy low; bytes go into a 14-entry frame memory
// while the 24-bit remainder is updated on the fly.
// output: result_valid is high for exactly one cycle with status,
// was_corrected, flipped_bit, icao_address, msg_type and me_payload.
// the receiver cannot stall; the result is held on the ports until the next one.
// processing after the last byte's transaction:
//   bad length: result shows in the next cycle, busy stays low
//   clean frame: 11 memory reads, then a classify state gives the result
//   syndrome nonzero: a search over the 112 bit positions first (one candidate bit
//   syndrome per cycle, x^(111-i) mod g, walked from the last bit down),
//   then the reads and classify on a hit, else an uncorrectable result
// reset clears the byte count, the remainder and the state machine; the frame
// memory keeps no reset and is always rewritten before it is read.
module adsb_frame_crc_correct_classify_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic        was_corrected,
    output logic [6:0]  flipped_bit,
    output logic [23:0] icao_address,
    output logic [4:0]  msg_type,
    output logic [55:0] me_payload
);
    import afcc_pkg::*;

    // control state
    state_t      state_reg, state_next;
    logic [3:0]  count_reg, count_next;
    logic [23:0] rem_reg, rem_next;
    logic [23:0] syn_reg, syn_next;
    logic [23:0] cand_reg, cand_next;
    logic [6:0]  idx_reg, idx_next;
    logic [3:0]  rd_cnt_reg, rd_cnt_next;
    logic        cap_reg, cap_next;
    logic [3:0]  cap_addr_reg;
    logic        corr_reg, corr_next;
    logic [6:0]  flip_reg, flip_next;

    // payload collected from memory
    logic [87:0] fr_reg;

    // result registers
    logic        res_valid_reg, res_valid_next;
    logic [2:0]  status_reg, status_next;
    logic        was_corr_reg, was_corr_next;
    logic [6:0]  flipped_reg, flipped_next;
    logic [23:0] icao_reg, icao_next;
    logic [4:0]  tc_reg, tc_next;
    logic [55:0] me_reg, me_next;

    // memory port signals
    logic        ram_we;
    logic [3:0]  ram_raddr;
    logic [7:0]  ram_rdata;

    logic        accept;
    logic [3:0]  count_inc;
    logic [23:0] rem_upd;
    logic [7:0]  byte_fixed;
    logic [87:0] word;
    logic [4:0]  word_df;
    logic [4:0]  word_tc;
    logic        cand_hit;

    assign accept    = start && (state_reg == S_IDLE);
    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 4'd1;
    assign rem_upd   = crc_absorb(rem_reg, count_reg, frame_byte);
    assign ram_we    = accept && (count_reg < LEN_GOOD);
    assign ram_raddr = rd_cnt_reg;
    assign cand_hit  = (cand_reg == syn_reg);

    // byte coming back from memory, repaired if it holds the flipped bit
    assign byte_fixed = ram_rdata ^
        ((corr_reg && (flip_reg[6:3] == cap_addr_reg)) ? (8'h80 >> flip_reg[2:0]) : 8'h00);
    assign word    = {fr_reg[79:0], byte_fixed};
    assign word_df = word[87:83];
    assign word_tc = word[55:51];

    afcc_ram #(
        .WIDTH(8),
        .DEPTH(FRAME_BYTES)
    ) u_frame_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg),
        .wdata(frame_byte),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && last_byte && (count_inc == LEN_GOOD))
                begin
                    state_next = (rem_upd == 24'h000000) ? S_READ : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (cand_hit)
                begin
                    state_next = S_READ;
                end
                else if (idx_reg == 7'd0)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (rd_cnt_reg == LAST_PAYLOAD_BYTE)
                begin
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        rem_next       = rem_reg;
        syn_next       = syn_reg;
        cand_next      = cand_reg;
        idx_next       = idx_reg;
        rd_cnt_next    = rd_cnt_reg;
        cap_next       = 1'b0;
        corr_next      = corr_reg;
        flip_next      = flip_reg;
        res_valid_next = 1'b0;
        status_next    = status_reg;
        was_corr_next  = was_corr_reg;
        flipped_next   = flipped_reg;
        icao_next      = icao_reg;
        tc_next        = tc_reg;
        me_next        = me_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_inc;
                    if (count_reg < LEN_GOOD)
                    begin
                        rem_next = rem_upd;
                    end
                    if (last_byte)
                    begin
                        // end of frame: restart the count and remainder
                        count_next  = 4'd0;
                        rem_next    = 24'h000000;
                        syn_next    = rem_upd;
                        cand_next   = 24'h000001;
                        idx_next    = LAST_BIT;
                        rd_cnt_next = 4'd0;
                        corr_next   = 1'b0;
                        flip_next   = 7'd0;
                        if (count_inc != LEN_GOOD)
                        begin
                            res_valid_next = 1'b1;
                            status_next    = ST_BAD_LEN;
                            was_corr_next  = 1'b0;
                            flipped_next   = 7'd0;
                            icao_next      = 24'h000000;
                            tc_next        = 5'd0;
                            me_next        = 56'h0;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                if (cand_hit)
                begin
                    corr_next = 1'b1;
                    flip_next = idx_reg;
                end
                else if (idx_reg == 7'd0)
                begin
                    res_valid_next = 1'b1;
                    status_next    = ST_UNCORR;
                    was_corr_next  = 1'b0;
                    flipped_next   = 7'd0;
                    icao_next      = 24'h000000;
                    tc_next        = 5'd0;
                    me_next        = 56'h0;
                end
                else
                begin
                    cand_next = crc_mul_x(cand_reg);
                    idx_next  = idx_reg - 7'd1;
                end
            end
            S_READ:
            begin
                cap_next    = 1'b1;
                rd_cnt_next = rd_cnt_reg + 4'd1;
            end
            S_CLASSIFY:
            begin
                res_valid_next = 1'b1;
                was_corr_next  = corr_reg;
                flipped_next   = flip_reg;
                if (word_df != DF_EXT_SQUITTER)
                begin
                    status_next = ST_NOT_DF17;
                    icao_next   = 24'h000000;
                    tc_next     = 5'd0;
                    me_next     = 56'h0;
                end
                else
                begin
                    icao_next = word[79:56];
                    tc_next   = word_tc;
                    me_next   = word[55:0];
                    priority if (word_tc >= TC_IDENT_LO && word_tc <= TC_IDENT_HI)
                    begin
                        status_next = ST_IDENT;
                    end
                    else if (word_tc >= TC_POS_LO && word_tc <= TC_POS_HI)
                    begin
                        status_next = ST_AIR_POS;
                    end
                    else if (word_tc == TC_VELOCITY)
                    begin
                        status_next = ST_VELOCITY;
                    end
                    else
                    begin
                        status_next = ST_OTHER;
                    end
                end
            end
            default:
            begin
                cap_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= 4'd0;
            rem_reg       <= 24'h000000;
            rd_cnt_reg    <= 4'd0;
            cap_reg       <= 1'b0;
            corr_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            rd_cnt_reg    <= rd_cnt_next;
            cap_reg       <= cap_next;
            corr_reg      <= corr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        syn_reg      <= syn_next;
        cand_reg     <= cand_next;
        idx_reg      <= idx_next;
        flip_reg     <= flip_next;
        cap_addr_reg <= rd_cnt_reg;
        if (cap_reg)
        begin
            fr_reg <= word;
        end
        status_reg   <= status_next;
        was_corr_reg <= was_corr_next;
        flipped_reg  <= flipped_next;
        icao_reg     <= icao_next;
        tc_reg       <= tc_next;
        me_reg       <= me_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = res_valid_reg;
    assign status        = status_reg;
    assign was_corrected = was_corr_reg;
    assign flipped_bit   = flipped_reg;
    assign icao_address  = icao_reg;
    assign msg_type      = tc_reg;
    assign me_payload    = me_reg;

    // the search only runs on a nonzero syndrome
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (syn_reg != 24'h000000))
        else $error("syndrome search entered with zero syndrome");

    // memory reads stay inside the payload bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (rd_cnt_reg <= LAST_PAYLOAD_BYTE))
        else $error("frame read address out of range");

    // a repaired frame never reports a length or crc failure
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && was_corrected) |->
        (status != ST_BAD_LEN && status != ST_UNCORR))
        else $error("corrected frame with failure status");

    // without a repair the bit index is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !was_corrected) |-> (flipped_bit == 7'd0))
        else $error("flipped bit reported without a repair");

    // the classify cycle always produces a transaction in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLASSIFY) |=> result_valid)
        else $error("classify did not produce a result");

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afcc_pkg::*;

    // run limits: the sender idles about 38 percent of the time
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 820;
    localparam int SETTLE_CYCLES = 150;
    localparam int NUM_BITS = 112;

    // one decoded squitter as the block reports it
    typedef struct packed {
        logic [2:0]  status;
        logic        corrected;
        logic [6:0]  flipped;
        logic [23:0] icao;
        logic [4:0]  tc;
        logic [55:0] me;
    } decode_t;

    // shapes of frames in the random traffic
    typedef enum int {
        FK_SQUITTER,
        FK_ANY_DF,
        FK_NOISE,
        FK_BAD_LEN
    } frame_kind_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  frame_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic [2:0]  status;
    logic        was_corrected;
    logic [6:0]  flipped_bit;
    logic [23:0] icao_address;
    logic [4:0]  msg_type;
    logic [55:0] me_payload;

    // decodes still owed by the block, oldest first
    decode_t expected_decodes[$];

    // predictor state: frame memory, byte count, running remainder
    logic [7:0]  rx_frame[14];
    logic [3:0]  rx_count = 4'd0;
    logic [23:0] rx_rem = 24'h000000;

    // syndrome left behind by a single flipped bit, per bit index
    logic [23:0] one_bit_syndrome[NUM_BITS];

    // bytes of the frame about to be sent
    logic [7:0] tx_bytes[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  bytes_sent = 0;
    bit  no_idle = 1'b0;

    adsb_frame_crc_correct_classify_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .frame_byte    (frame_byte),
        .last_byte     (last_byte),
        .result_valid  (result_valid),
        .status        (status),
        .was_corrected (was_corrected),
        .flipped_bit   (flipped_bit),
        .icao_address  (icao_address),
        .msg_type      (msg_type),
        .me_payload    (me_payload)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog on a hung handshake or a lost result
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // crc-24 fold, bit serial: data bit enters at the feedback tap;
    // parity bytes are xored straight into the remainder
    function automatic logic [23:0] crc_fold(
        input logic [23:0] rem,
        input logic [3:0]  pos,
        input logic [7:0]  b
    );
        logic [23:0] r;
        logic        fb;
        r = rem;
        if (pos < PARITY_START)
        begin
            for (int k = 7; k >= 0; k--)
            begin
                fb = r[23] ^ b[k];
                r = {r[22:0], 1'b0};
                if (fb)
                begin
                    r = r ^ POLY_LOW;
                end
            end
        end
        else if (pos == PARITY_START)
        begin
            r[23:16] = r[23:16] ^ b;
        end
        else if (pos == PARITY_MID)
        begin
            r[15:8] = r[15:8] ^ b;
        end
        else if (pos == PARITY_END)
        begin
            r[7:0] = r[7:0] ^ b;
        end
        return r;
    endfunction

    // predictor: absorb one accepted byte, on the last byte queue the decode
    task automatic absorb_and_decode(input logic [7:0] b, input logic last);
        logic [7:0] fr[14];
        decode_t    d;
        logic       found;
        if (rx_count < LEN_GOOD)
        begin
            rx_frame[rx_count] = b;
            rx_rem = crc_fold(rx_rem, rx_count, b);
        end
        // count saturates, extra bytes are dropped
        if (rx_count < COUNT_MAX)
        begin
            rx_count = rx_count + 4'd1;
        end
        if (!last)
        begin
            return;
        end
        d = '0;
        if (rx_count != LEN_GOOD)
        begin
            d.status = ST_BAD_LEN;
        end
        else
        begin
            fr = rx_frame;
            found = (rx_rem == 24'h000000);
            // single-bit syndromes are distinct, so at most one can match
            for (int i = 0; i < NUM_BITS; i++)
            begin
                if (!found && one_bit_syndrome[i] == rx_rem)
                begin
                    fr[i / 8] = fr[i / 8] ^ (8'h80 >> (i % 8));
                    d.corrected = 1'b1;
                    d.flipped = 7'(i);
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                d.status = ST_UNCORR;
            end
            else if (fr[0][7:3] != DF_EXT_SQUITTER)
            begin
                d.status = ST_NOT_DF17;
            end
            else
            begin
                d.icao = {fr[1], fr[2], fr[3]};
                d.tc = fr[4][7:3];
                d.me = {fr[4], fr[5], fr[6], fr[7], fr[8], fr[9], fr[10]};
                if (d.tc >= TC_IDENT_LO && d.tc <= TC_IDENT_HI)
                begin
                    d.status = ST_IDENT;
                end
                else if (d.tc >= TC_POS_LO && d.tc <= TC_POS_HI)
                begin
                    d.status = ST_AIR_POS;
                end
                else if (d.tc == TC_VELOCITY)
                begin
                    d.status = ST_VELOCITY;
                end
                else
                begin
                    d.status = ST_OTHER;
                end
            end
        end
        rx_count = 4'd0;
        rx_rem = 24'h000000;
        expected_decodes.push_back(d);
    endtask

    // result checker: the block cannot be stalled, every strobe is a transaction
    always @(posedge clk)
    begin : check_results
        decode_t want;
        if (rst_n && result_valid)
        begin
            if (expected_decodes.size() == 0)
            begin
                $error("unexpected result: status %0d", status);
                error_count++;
            end
            else
            begin
                want = expected_decodes.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, status);
                    error_count++;
                end
                if (was_corrected !== want.corrected)
                begin
                    $error("was_corrected: expected %0d actual %0d",
                           want.corrected, was_corrected);
                    error_count++;
                end
                if (flipped_bit !== want.flipped)
                begin
                    $error("flipped_bit: expected %0d actual %0d", want.flipped, flipped_bit);
                    error_count++;
                end
                if (icao_address !== want.icao)
                begin
                    $error("icao_address: expected %h actual %h", want.icao, icao_address);
                    error_count++;
                end
                if (msg_type !== want.tc)
                begin
                    $error("msg_type: expected %0d actual %0d", want.tc, msg_type);
                    error_count++;
                end
                if (me_payload !== want.me)
                begin
                    $error("me_payload: expected %h actual %h", want.me, me_payload);
                    error_count++;
                end
            end
        end
    end

    // one byte transaction with random idle cycles in front
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(0, 99) < 38)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        frame_byte <= b;
        last_byte <= last;
        // busy read right after the edge is the value the block saw
        do
            @(posedge clk);
        while (busy);
        bytes_sent++;
        absorb_and_decode(b, last);
    endtask

    task automatic send_frame();
        for (int n = 0; n < tx_bytes.size(); n++)
        begin
            send_byte(tx_bytes[n], n == tx_bytes.size() - 1);
        end
    endtask

    // hold the sender until every owed decode has come out
    task automatic wait_drain();
        start <= 1'b0;
        while (expected_decodes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // 11 data bytes followed by the parity that clears the remainder
    task automatic make_frame(
        input logic [4:0]  df,
        input logic [2:0]  ca,
        input logic [23:0] icao,
        input logic [55:0] me
    );
        logic [87:0] data;
        logic [23:0] r;
        data = {df, ca, icao, me};
        r = 24'h000000;
        tx_bytes.delete();
        for (int p = 0; p < 11; p++)
        begin
            tx_bytes.push_back(data[87 - 8 * p -: 8]);
            r = crc_fold(r, 4'(p), data[87 - 8 * p -: 8]);
        end
        tx_bytes.push_back(r[23:16]);
        tx_bytes.push_back(r[15:8]);
        tx_bytes.push_back(r[7:0]);
    endtask

    task automatic flip_bit(input int i);
        tx_bytes[i / 8] = tx_bytes[i / 8] ^ (8'h80 >> (i % 8));
    endtask

    task automatic make_noise(input int len);
        tx_bytes.delete();
        for (int n = 0; n < len; n++)
        begin
            tx_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic logic [55:0] rand_me(input logic [4:0] tc);
        return {tc, 51'({$urandom(), $urandom()})};
    endfunction

    // every type code band and its edges, with extreme addresses and payloads
    task automatic test_type_classes();
        logic [4:0] codes[10] = '{5'd0, TC_IDENT_LO, TC_IDENT_HI, 5'd5, TC_POS_LO,
                                   TC_POS_HI, TC_VELOCITY, 5'd20, 5'd8, 5'd31};
        for (int n = 0; n < 10; n++)
        begin
            if (n % 2 == 0)
            begin
                make_frame(DF_EXT_SQUITTER, 3'd0, 24'h000000, {codes[n], 51'h0});
            end
            else
            begin
                make_frame(DF_EXT_SQUITTER, 3'd7, 24'hFFFFFF, {codes[n], {51{1'b1}}});
            end
            send_frame();
        end
        wait_drain();
    endtask

    // single flipped bits at the frame ends, in the df field and in the parity
    task automatic test_single_bit_repair();
        int spots[6] = '{0, 4, 37, 87, 88, 111};
        for (int n = 0; n < 6; n++)
        begin
            make_frame(DF_EXT_SQUITTER, 3'd5, 24'($urandom()), rand_me(TC_VELOCITY));
            flip_bit(spots[n]);
            send_frame();
        end
        wait_drain();
    endtask

    // valid parity but another downlink format, also after a repair
    task automatic test_not_extended_squitter();
        make_frame(5'd0, 3'd0, 24'h000000, 56'h0);
        send_frame();
        make_frame(5'd31, 3'd7, 24'hFFFFFF, {56{1'b1}});
        send_frame();
        make_frame(5'd11, 3'd2, 24'($urandom()), rand_me(TC_POS_LO));
        flip_bit(60);
        send_frame();
        make_frame(5'd18, 3'd1, 24'($urandom()), rand_me(TC_IDENT_LO));
        flip_bit(3);
        send_frame();
    endtask

    // two flipped bits and raw noise
    task automatic test_uncorrectable();
        make_frame(DF_EXT_SQUITTER, 3'd5, 24'($urandom()), rand_me(TC_POS_HI));
        flip_bit(0);
        flip_bit(111);
        send_frame();
        tx_bytes.delete();
        for (int n = 0; n < FRAME_BYTES; n++)
        begin
            tx_bytes.push_back(8'hFF);
        end
        send_frame();
        make_noise(FRAME_BYTES);
        send_frame();
    endtask

    // short and long frames, count saturation, then a clean frame to recover
    task automatic test_bad_length();
        int lens[5] = '{1, 2, 13, 15, 20};
        for (int n = 0; n < 5; n++)
        begin
            make_noise(lens[n]);
            send_frame();
        end
        make_frame(DF_EXT_SQUITTER, 3'd5, 24'($urandom()), rand_me(TC_IDENT_HI));
        send_frame();
        wait_drain();
    endtask

    // mostly well-formed squitters with random content and errors, plus noise
    task automatic test_random_traffic();
        int          stop_at;
        int          frame_no;
        int          roll;
        int          b1;
        frame_kind_t kind;
        logic [4:0]  tc;
        stop_at = bytes_sent + RANDOM_BYTES;
        frame_no = 0;
        while (bytes_sent < stop_at)
        begin
            // a long stretch with the sender never idling
            no_idle = (frame_no >= 20 && frame_no < 45);
            if (frame_no == 50)
            begin
                wait_drain();
            end
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                kind = FK_SQUITTER;
            end
            else if (roll < 75)
            begin
                kind = FK_ANY_DF;
            end
            else if (roll < 85)
            begin
                kind = FK_NOISE;
            end
            else
            begin
                kind = FK_BAD_LEN;
            end
            case (kind)
                FK_SQUITTER:
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 25)
                    begin
                        tc = 5'($urandom_range(TC_IDENT_LO, TC_IDENT_HI));
                    end
                    else if (roll < 55)
                    begin
                        tc = 5'($urandom_range(TC_POS_LO, TC_POS_HI));
                    end
                    else if (roll < 70)
                    begin
                        tc = TC_VELOCITY;
                    end
                    else
                    begin
                        tc = 5'($urandom_range(0, 31));
                    end
                    make_frame(DF_EXT_SQUITTER, 3'($urandom_range(0, 7)), 24'($urandom()),
                               rand_me(tc));
                    roll = $urandom_range(0, 99);
                    if (roll >= 50)
                    begin
                        b1 = $urandom_range(0, NUM_BITS - 1);
                        flip_bit(b1);
                        if (roll >= 85)
                        begin
                            flip_bit((b1 + 1 + $urandom_range(0, NUM_BITS - 2)) % NUM_BITS);
                        end
                    end
                end
                FK_ANY_DF:
                begin
                    make_frame(5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                               24'($urandom()), 56'({$urandom(), $urandom()}));
                    if ($urandom_range(0, 2) == 0)
                    begin
                        flip_bit($urandom_range(0, NUM_BITS - 1));
                    end
                end
                FK_NOISE:
                begin
                    make_noise(FRAME_BYTES);
                end
                default:
                begin
                    roll = $urandom_range(1, 19);
                    make_noise(roll == FRAME_BYTES ? 20 : roll);
                end
            endcase
            send_frame();
            frame_no++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            rx_frame[i] = 8'h00;
        end
        // syndrome of each lone bit error over a full frame
        for (int i = 0; i < NUM_BITS; i++)
        begin
            one_bit_syndrome[i] = 24'h000000;
            for (int p = 0; p < FRAME_BYTES; p++)
            begin
                one_bit_syndrome[i] = crc_fold(one_bit_syndrome[i], 4'(p),
                                               (p == i / 8) ? (8'h80 >> (i % 8)) : 8'h00);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_type_classes();
        test_single_bit_repair();
        test_not_extended_squitter();
        test_uncorrectable();
        test_bad_length();
        test_random_traffic();

        // let the last decode and any stray strobe come out
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
